FILE: rtl/core/did_pkg.sv
// Package for the delta instruction decoder: payload words, kinds, error causes.
// No dependencies.
package did_pkg;

    typedef enum logic [1:0] {
        KIND_COPY = 2'd0,
        KIND_LIT  = 2'd1,
        KIND_OK   = 2'd2,
        KIND_FAIL = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_HDR_CUT  = 4'd1,
        ERR_BASE     = 4'd2,
        ERR_RANGE    = 4'd3,
        ERR_OVERFLOW = 4'd4,
        ERR_CMD_ZERO = 4'd5,
        ERR_TRUNC    = 4'd6,
        ERR_SHORT    = 4'd7,
        ERR_HDR_WIDE = 4'd8
    } t_err;

    typedef struct packed {
        logic [7:0] delta_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  op_kind;
        logic [31:0] source_offset;
        logic [23:0] copy_count;
        logic [7:0]  literal_value;
        logic [31:0] dest_position;
        logic [3:0]  error_cause;
        logic [31:0] result_length;
        logic        last_result;
    } t_out_word;

    localparam logic [23:0] COPY_ZERO_LEN = 24'h010000;

endpackage

FILE: rtl/core/did_fifo.sv
// Small two-entry register queue of packed words.
// Depends on nothing; the word type comes in as a type parameter.
module did_fifo #(
    parameter type T = logic [7:0]
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output T     o_data
);
    T           r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_data  = r_mem[r_rp];

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && !o_empty) ? 1 : 0);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end
endmodule

FILE: rtl/core/did_front.sv
// Front part: header varints, command classification and parameter gathering.
// Depends on did_pkg. Emits up to two words per byte into a result queue.
module did_front #(
    parameter int SIZE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_base_length,
    input  logic                 i_valid,
    input  did_pkg::t_in_word    i_word,
    output logic                 o_ready,
    output logic                 o_v0,
    output did_pkg::t_out_word   o_w0,
    output logic                 o_v1,
    output did_pkg::t_out_word   o_w1,
    input  logic [1:0]           i_space
);
    localparam int MAXH = (SIZE_BITS + 6) / 7;
    localparam int HB   = $clog2(MAXH + 1);

    typedef enum logic [2:0] {
        PH_BASE, PH_RES, PH_CMD, PH_COPY, PH_LIT, PH_FAIL
    } t_phase;

    t_phase               r_ph, n_ph;
    logic [HB-1:0]        r_seen, n_seen;
    logic [SIZE_BITS-1:0] r_vv, n_vv, r_decl, n_decl, r_rem, n_rem;
    logic [6:0]           r_flags, n_flags;
    logic [31:0]          r_off, n_off;
    logic [23:0]          r_len, n_len;
    logic [6:0]           r_litl, n_litl;
    logic [31:0]          r_wpos, n_wpos;
    logic                 r_failed, n_failed;
    did_pkg::t_err        r_err, n_err;

    logic [7:0] b;
    logic       go;
    assign b       = i_word.delta_byte;
    assign o_ready = i_space == 2'd2;
    assign go      = i_valid && o_ready;

    // header byte helpers
    logic [SIZE_BITS+6:0] hshift;
    logic                 hwide, hdone, hcont_err;
    logic [SIZE_BITS-1:0] hval;
    always_comb begin
        hshift    = (SIZE_BITS+7)'(b[6:0]) << (7 * r_seen);
        hwide     = |hshift[SIZE_BITS+6:SIZE_BITS];
        hval      = r_vv | hshift[SIZE_BITS-1:0];
        hdone     = !b[7];
        hcont_err = b[7] && (32'(r_seen) + 32'd1 >= 32'(MAXH));
    end

    // copy check on the gathered parameters
    function automatic void copy_chk(input logic [31:0] off, input logic [23:0] len,
                                     input logic [31:0] bl, input logic [SIZE_BITS-1:0] rem,
                                     output logic [23:0] l, output logic bad_rng,
                                     output logic bad_ovf);
        l       = (len == 24'd0) ? did_pkg::COPY_ZERO_LEN : len;
        bad_rng = ({1'b0, off} + 33'(l)) > {1'b0, bl};
        bad_ovf = 64'(l) > 64'(rem);
    endfunction

    logic [6:0]  fsel, fsel_low;
    logic [2:0]  fbit;
    logic [31:0] off_g;
    logic [23:0] len_g, cl;
    logic        crng, covf, do_cp;

    did_pkg::t_out_word w0, w1;

    always_comb begin
        n_ph = r_ph; n_seen = r_seen; n_vv = r_vv; n_decl = r_decl; n_rem = r_rem;
        n_flags = r_flags; n_off = r_off; n_len = r_len; n_litl = r_litl;
        n_wpos = r_wpos; n_failed = r_failed; n_err = r_err;
        o_v0 = 1'b0; o_v1 = 1'b0;
        w0 = '0; w1 = '0;
        fsel = '0; fbit = '0; off_g = r_off; len_g = r_len; do_cp = 1'b0;
        fsel_low = r_flags & (~r_flags + 7'd1);
        for (int k = 0; k < 7; k++) if (fsel_low[k]) fbit = 3'(k);
        cl = '0; crng = 1'b0; covf = 1'b0;
        if (go) begin
            case (r_ph)
                PH_BASE, PH_RES: begin
                    if (hwide || hcont_err) begin
                        n_ph = PH_FAIL; n_failed = 1'b1; n_err = did_pkg::ERR_HDR_WIDE;
                    end else begin
                        n_vv   = hval;
                        n_seen = r_seen + HB'(1);
                        if (hdone) begin
                            if (r_ph == PH_BASE) begin
                                if (64'(hval) != 64'(i_base_length)) begin
                                    n_ph = PH_FAIL; n_failed = 1'b1;
                                    n_err = did_pkg::ERR_BASE;
                                end else begin
                                    n_ph = PH_RES; n_vv = '0; n_seen = '0;
                                end
                            end else begin
                                n_decl = hval; n_rem = hval; n_ph = PH_CMD;
                            end
                        end
                    end
                end
                PH_CMD: begin
                    if (b[7]) begin
                        n_flags = b[6:0]; n_off = '0; n_len = '0;
                        off_g = '0; len_g = '0;
                        if (b[6:0] == 7'd0) do_cp = 1'b1;
                        else n_ph = PH_COPY;
                    end else if (b != 8'd0) begin
                        if (64'(b) > 64'(r_rem)) begin
                            n_ph = PH_FAIL; n_failed = 1'b1; n_err = did_pkg::ERR_OVERFLOW;
                        end else begin
                            n_litl = b[6:0]; n_ph = PH_LIT;
                        end
                    end else begin
                        n_ph = PH_FAIL; n_failed = 1'b1; n_err = did_pkg::ERR_CMD_ZERO;
                    end
                end
                PH_COPY: begin
                    fsel = r_flags & ~fsel_low;
                    n_flags = fsel;
                    if (fbit < 3'd4) off_g = r_off | (32'(b) << (8 * fbit[1:0]));
                    else len_g = r_len | (24'(b) << (8 * 32'(fbit - 3'd4)));
                    n_off = off_g; n_len = len_g;
                    if (fsel == 7'd0) do_cp = 1'b1;
                end
                PH_LIT: begin
                    o_v0 = 1'b1;
                    w0.op_kind = did_pkg::KIND_LIT;
                    w0.literal_value = b;
                    w0.dest_position = r_wpos;
                    n_wpos = r_wpos + 32'd1;
                    if (r_rem != '0) n_rem = r_rem - SIZE_BITS'(1);
                    if (r_litl != 7'd0) n_litl = r_litl - 7'd1;
                    if (r_litl <= 7'd1) n_ph = PH_CMD;
                end
                default: ;
            endcase
            if (do_cp) begin
                copy_chk(off_g, len_g, i_base_length, r_rem, cl, crng, covf);
                if (crng) begin
                    n_ph = PH_FAIL; n_failed = 1'b1; n_err = did_pkg::ERR_RANGE;
                end else if (covf) begin
                    n_ph = PH_FAIL; n_failed = 1'b1; n_err = did_pkg::ERR_OVERFLOW;
                end else begin
                    o_v0 = 1'b1;
                    w0.op_kind = did_pkg::KIND_COPY;
                    w0.source_offset = off_g;
                    w0.copy_count = cl;
                    w0.dest_position = r_wpos;
                    n_wpos = r_wpos + 32'(cl);
                    n_rem = r_rem - SIZE_BITS'(cl);
                    n_flags = '0; n_ph = PH_CMD;
                end
            end
            // end of stream status
            if (i_word.last_byte) begin
                if (!n_failed) begin
                    n_failed = 1'b1;
                    if (n_ph == PH_BASE || n_ph == PH_RES) n_err = did_pkg::ERR_HDR_CUT;
                    else if (n_ph == PH_COPY || n_ph == PH_LIT) n_err = did_pkg::ERR_TRUNC;
                    else if (n_rem != '0) n_err = did_pkg::ERR_SHORT;
                    else n_failed = 1'b0;
                end
                w1 = '0;
                w1.last_result = 1'b1;
                if (n_failed) begin
                    w1.op_kind = did_pkg::KIND_FAIL; w1.error_cause = n_err;
                end else begin
                    w1.op_kind = did_pkg::KIND_OK; w1.result_length = 32'(n_decl);
                end
                o_v1 = 1'b1;
                n_ph = PH_BASE; n_seen = '0; n_vv = '0; n_decl = '0; n_rem = '0;
                n_flags = '0; n_off = '0; n_len = '0; n_litl = '0; n_wpos = '0;
                n_failed = 1'b0; n_err = did_pkg::ERR_NONE;
            end
        end
        o_w0 = w0;
        o_w1 = w1;
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_BASE; r_seen <= '0; r_vv <= '0; r_decl <= '0; r_rem <= '0;
            r_flags <= '0; r_off <= '0; r_len <= '0; r_litl <= '0; r_wpos <= '0;
            r_failed <= 1'b0; r_err <= did_pkg::ERR_NONE;
        end else begin
            r_ph <= n_ph; r_seen <= n_seen; r_vv <= n_vv; r_decl <= n_decl;
            r_rem <= n_rem; r_flags <= n_flags; r_off <= n_off; r_len <= n_len;
            r_litl <= n_litl; r_wpos <= n_wpos; r_failed <= n_failed; r_err <= n_err;
        end
    end
endmodule

FILE: rtl/core/did_back.sv
// Back part: orders up to two words per byte into the output queue.
// Depends on did_pkg.
module did_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_v0,
    input  did_pkg::t_out_word i_w0,
    input  logic               i_v1,
    input  did_pkg::t_out_word i_w1,
    output logic [1:0]         o_space,
    input  logic               i_pop,
    output logic               o_empty,
    output did_pkg::t_out_word o_word
);
    // four-entry queue, two writes a cycle
    did_pkg::t_out_word r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [2:0] nwr;
    logic       deq;

    assign o_empty = r_cnt == 3'd0;
    assign o_word  = r_q[r_rp];
    assign deq     = i_pop && !o_empty;
    assign nwr     = 3'(i_v0) + 3'(i_v1);
    assign o_space = (r_cnt <= 3'd2) ? 2'd2 : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + nwr[1:0];
            if (deq) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + nwr - 3'(deq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_v0) r_q[r_wp] <= i_w0;
        if (i_v1) r_q[r_wp + 2'(i_v0)] <= i_w1;
    end
endmodule

FILE: rtl/core/delta_instruction_decoder.sv
// Delta instruction decoder: takes one delta byte per cycle and produces
// copy orders, literal bytes and one status word per stream. The parser takes
// a byte every cycle the result queue has room for two words; the header,
// command and parameter parse takes one step per byte, so sustained
// rate is one byte per cycle while results are drained. Bytes pass
// through the input queue, the parser and the result queue.
// Depends on did_pkg, did_fifo, did_front, did_back.
module delta_instruction_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  did_pkg::t_in_word  i_in,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output did_pkg::t_out_word o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    logic [31:0]        r_base_length;
    logic               q_empty, f_ready, v0, v1;
    did_pkg::t_in_word  q_word;
    did_pkg::t_out_word w0, w1;
    logic [1:0]         space;

    assign o_cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_base_length <= '0;
        else if (i_cfg_valid) r_base_length <= i_cfg_data;
    end

    did_fifo #(.T(did_pkg::t_in_word)) u_inq (
        .i_clk, .i_rst_n, .i_push(push), .i_data(i_in), .o_full(full),
        .i_pop(f_ready), .o_empty(q_empty), .o_data(q_word)
    );

    did_front #(.SIZE_BITS(SIZE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_base_length(r_base_length),
        .i_valid(!q_empty), .i_word(q_word), .o_ready(f_ready),
        .o_v0(v0), .o_w0(w0), .o_v1(v1), .o_w1(w1), .i_space(space)
    );

    did_back u_back (
        .i_clk, .i_rst_n, .i_v0(v0), .i_w0(w0), .i_v1(v1), .i_w1(w1),
        .o_space(space), .i_pop(pop), .o_empty(empty), .o_word(o_out)
    );
endmodule

FILE: rtl/core/did_check.sv
// Port checker for the delta instruction decoder, bound to the top level.
// Depends on did_pkg.
module did_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input did_pkg::t_out_word o_out
);
    // a waiting word holds while not popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_out)) else $error("word changed while stalled");
    // status words carry the end mark
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_out.op_kind == did_pkg::KIND_OK || o_out.op_kind == did_pkg::KIND_FAIL)
        |-> o_out.last_result) else $error("status without end mark");
    // copy and literal words carry no error
    a_noerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_out.op_kind == did_pkg::KIND_COPY || o_out.op_kind == did_pkg::KIND_LIT)
        |-> o_out.error_cause == did_pkg::ERR_NONE && !o_out.last_result)
        else $error("data word with status");
    // a failure has a cause
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out.op_kind == did_pkg::KIND_FAIL |-> o_out.error_cause != did_pkg::ERR_NONE)
        else $error("failure without cause");
endmodule

bind delta_instruction_decoder did_check u_did_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop), .o_out(o_out)
);
